[sv/srit_pkg.sv]
// Shared types and codes for the sorted insert record table.
// Used by srit_cell, the top level sorted_insert_record_table_unit and srit_checker.
package srit_pkg;

  typedef struct packed {
    logic [23:0] code;
    logic [7:0]  age;
    logic [23:0] price_cents;
    logic [15:0] quantity;
  } rec_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DUMP   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ENTRY    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    logic     key_mode;
    rec_t     new_rec;
  } cell_ctrl_t;

  // Register index decoded from paddr[2].
  localparam logic REG_SORT_KEY_MODE = 1'b0;

endpackage

[sv/srit_cell.sv]
// One slot of the sorted record chain: holds a record, compares its key against
// the incoming one and takes data from a neighbor on insert or rotate.
// Depends on srit_pkg.
module srit_cell (
  input  logic                   clk,
  input  srit_pkg::cell_ctrl_t   ctrl,
  input  logic                   occupied,
  input  logic                   is_tail,
  input  logic                   t_upper,
  input  logic                   t_lower,
  input  srit_pkg::rec_t         rec_upper,
  input  srit_pkg::rec_t         rec_lower,
  input  srit_pkg::rec_t         rec_head,
  output logic                   t_out,
  output logic                   load,
  output srit_pkg::rec_t         rec
);

  srit_pkg::rec_t rec_r;
  srit_pkg::rec_t rec_nxt;
  logic [15:0]    own_key;
  logic [15:0]    new_key;
  logic           gt;

  always_comb begin
    own_key = ctrl.key_mode ? {8'd0, rec_r.age} : rec_r.quantity;
    new_key = ctrl.key_mode ? {8'd0, ctrl.new_rec.age} : ctrl.new_rec.quantity;
    gt      = new_key < own_key;
    // Set when this entry and every occupied entry above it must move up.
    t_out   = occupied ? (gt && t_upper) : 1'b1;
    load    = (ctrl.op == srit_pkg::CELL_INSERT) && t_out && !t_lower;
  end

  always_comb begin
    rec_nxt = rec_r;
    unique case (ctrl.op)
      srit_pkg::CELL_HOLD: rec_nxt = rec_r;
      srit_pkg::CELL_INSERT: begin
        if (t_out && t_lower) begin
          rec_nxt = rec_lower;
        end else if (t_out) begin
          rec_nxt = ctrl.new_rec;
        end
      end
      srit_pkg::CELL_ROTATE: rec_nxt = is_tail ? rec_head : rec_upper;
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

[sv/sorted_insert_record_table_unit.sv]
// Channel   Direction  Ports                                   Transaction
// input     in         in_valid/in_ready, in_opcode, in_new_*  one command
// result    out        out_valid/out_ready, out_status ...     one result record
// config    in/out     psel penable pwrite paddr pwdata prdata pready  register access
//
// Insert, clear, rejected insert and dump of an empty table: one result in the output register.
// Dump: after the accept, cell 0 is emitted once per stored entry while the
// occupied part of the chain rotates down by one when the output register is free.
// A new command is accepted only when idle and the output register is free.
// rst_n is synchronous; it empties the table and clears the sort key mode.
// Top level: chain of srit_cell, control FSM, output register. Depends on srit_pkg.
module sorted_insert_record_table_unit #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [23:0] in_new_code,
  input  logic [7:0]  in_new_age,
  input  logic [23:0] in_new_price_cents,
  input  logic [15:0] in_new_quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_position,
  output logic [23:0] out_code,
  output logic [7:0]  out_age,
  output logic [23:0] out_price_cents,
  output logic [15:0] out_quantity,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  srit_pkg::fsm_state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 mode_r;

  logic                 out_valid_r;
  srit_pkg::status_t    out_status_r;
  logic [5:0]           out_position_r;
  srit_pkg::rec_t       out_rec_r;
  logic                 out_last_r;

  logic                 out_free;
  logic                 in_fire;
  logic                 dump_fire;
  logic                 full;
  logic                 dump_last;
  logic [CW:0]          idx_inc;
  srit_pkg::opcode_t    op;

  srit_pkg::cell_ctrl_t cell_ctrl;
  srit_pkg::rec_t       cell_rec [DEPTH];
  logic [DEPTH-1:0]     cell_t;
  logic [DEPTH-1:0]     cell_load;
  logic [IW-1:0]        ins_pos;

  logic                 res_load;
  srit_pkg::status_t    res_status;
  logic [5:0]           res_pos;
  srit_pkg::rec_t       res_rec;
  logic                 res_last;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == srit_pkg::REG_SORT_KEY_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == srit_pkg::REG_SORT_KEY_MODE) begin
      mode_r <= pwdata[0];
    end
  end

  // Control
  always_comb begin
    op        = srit_pkg::opcode_t'(in_opcode);
    out_free  = !out_valid_r || out_ready;
    full      = count_r == CW'(DEPTH);
    idx_inc   = (CW+1)'(idx_r) + (CW+1)'(1);
    dump_last = idx_inc == (CW+1)'(count_r);
  end

  always_comb begin
    in_ready  = 1'b0;
    dump_fire = 1'b0;
    unique case (state_r)
      srit_pkg::FSM_IDLE: in_ready  = out_free;
      srit_pkg::FSM_DUMP: dump_fire = out_free;
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srit_pkg::FSM_IDLE: begin
        if (in_fire && op == srit_pkg::OP_DUMP && count_r != '0) begin
          state_nxt = srit_pkg::FSM_DUMP;
        end
      end
      srit_pkg::FSM_DUMP: begin
        if (dump_fire && dump_last) begin
          state_nxt = srit_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = srit_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (dump_fire) begin
      idx_nxt = idx_r + IW'(1);
    end else if (in_fire) begin
      idx_nxt = '0;
      if (op == srit_pkg::OP_INSERT && !full) begin
        count_nxt = count_r + CW'(1);
      end else if (op == srit_pkg::OP_CLEAR) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srit_pkg::FSM_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Cell chain
  always_comb begin
    cell_ctrl.key_mode             = mode_r;
    cell_ctrl.new_rec.code         = in_new_code;
    cell_ctrl.new_rec.age          = in_new_age;
    cell_ctrl.new_rec.price_cents  = in_new_price_cents;
    cell_ctrl.new_rec.quantity     = in_new_quantity;
    if (dump_fire) begin
      cell_ctrl.op = srit_pkg::CELL_ROTATE;
    end else if (in_fire && op == srit_pkg::OP_INSERT && !full) begin
      cell_ctrl.op = srit_pkg::CELL_INSERT;
    end else begin
      cell_ctrl.op = srit_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic           t_up, t_lo;
    srit_pkg::rec_t r_up, r_lo;

    if (i == DEPTH - 1) begin : g_top
      assign t_up = 1'b1;
      assign r_up = cell_rec[i];
    end else begin : g_mid
      assign t_up = cell_t[i+1];
      assign r_up = cell_rec[i+1];
    end

    if (i == 0) begin : g_bot
      assign t_lo = 1'b0;
      assign r_lo = cell_rec[i];
    end else begin : g_low
      assign t_lo = cell_t[i-1];
      assign r_lo = cell_rec[i-1];
    end

    srit_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .occupied  (CW'(i) < count_r),
      .is_tail   (CW'(i + 1) == count_r),
      .t_upper   (t_up),
      .t_lower   (t_lo),
      .rec_upper (r_up),
      .rec_lower (r_lo),
      .rec_head  (cell_rec[0]),
      .t_out     (cell_t[i]),
      .load      (cell_load[i]),
      .rec       (cell_rec[i])
    );
  end

  // Encode the one-hot insertion point
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_load[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  // Result selection
  always_comb begin
    res_load   = 1'b0;
    res_status = srit_pkg::ST_INSERTED;
    res_pos    = '0;
    res_rec    = '0;
    res_last   = 1'b1;
    priority if (dump_fire) begin
      res_load   = 1'b1;
      res_status = srit_pkg::ST_ENTRY;
      res_pos    = 6'(idx_r);
      res_rec    = cell_rec[0];
      res_last   = dump_last;
    end else if (in_fire) begin
      unique case (op)
        srit_pkg::OP_INSERT: begin
          res_load = 1'b1;
          if (full) begin
            res_status = srit_pkg::ST_FULL;
          end else begin
            res_status = srit_pkg::ST_INSERTED;
            res_pos    = 6'(ins_pos);
          end
        end
        srit_pkg::OP_DUMP: begin
          if (count_r == '0) begin
            res_load   = 1'b1;
            res_status = srit_pkg::ST_EMPTY;
          end
        end
        srit_pkg::OP_CLEAR: begin
          res_load   = 1'b1;
          res_status = srit_pkg::ST_CLEARED;
        end
        default: ; // drop the unused opcode
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r   <= res_status;
      out_position_r <= res_pos;
      out_rec_r      <= res_rec;
      out_last_r     <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_code        = out_rec_r.code;
  assign out_age         = out_rec_r.age;
  assign out_price_cents = out_rec_r.price_cents;
  assign out_quantity    = out_rec_r.quantity;
  assign out_last        = out_last_r;

endmodule

[sv/srit_checker.sv]
// Port-level checks for sorted_insert_record_table_unit, attached by bind.
// Depends on srit_pkg.
module srit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [5:0]  out_position,
  input logic [23:0] out_code,
  input logic        out_last
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_code) && $stable(out_last))
    else $error("stalled result changed");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == srit_pkg::OP_CLEAR |=>
      out_valid && out_status == srit_pkg::ST_CLEARED && out_last)
    else $error("clear did not produce a cleared result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != srit_pkg::ST_ENTRY |-> out_last)
    else $error("single result without last");

  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == srit_pkg::ST_ENTRY && !out_last |-> !in_ready)
    else $error("command accepted during a dump");

endmodule

bind sorted_insert_record_table_unit srit_checker u_srit_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_opcode    (in_opcode),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_position (out_position),
  .out_code     (out_code),
  .out_last     (out_last)
);
